// ===== hdl/imutcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imutcf_pkg: shared types and constants of the tilt complementary filter
// Angle constants, CORDIC arctangent table, front-to-back queue entry type.
// ----------------------------------------------------------------------------
package imutcf_pkg;

    localparam int unsigned TabLen = 24;
    localparam logic signed [31:0] Deg90  = 32'sd5898240;
    localparam logic signed [31:0] Deg180 = 32'sd11796480;
    localparam logic signed [31:0] Deg360 = 32'sd23592960;

    // Register indexes of the configuration port
    localparam logic [1:0] RegBlend   = 2'd0;
    localparam logic [1:0] RegGain    = 2'd1;
    localparam logic [1:0] RegGravity = 2'd2;

    // Item passed from the front end to the back end
    typedef struct packed {
        logic               cal;
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [15:0] c3;
        logic signed [15:0] c4;
        logic signed [15:0] c5;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_PREP,
        S_CORD,
        S_BLEND,
        S_MUL,
        S_DONE
    } t_bstate;

    // atan(2^-i) in degrees, Q16.16
    function automatic logic signed [31:0] atan_tab(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/imutcf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imutcf_front: calibration and offset removal
// Sums the first calibration samples, latches offsets, then subtracts them.
// Offsets come from a reciprocal multiply of each sum, one axis per cycle.
// ----------------------------------------------------------------------------
module imutcf_front #(
    parameter int unsigned CAL_SAMPLES = 100
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [95:0]         i_data,
    input  wire  [14:0]         i_gravity,
    output logic                o_valid,
    input  wire                 i_ready,
    output imutcf_pkg::t_work   o_work
);
    localparam int CW = $clog2(CAL_SAMPLES + 1);
    localparam logic [CW-1:0] CalN = CW'(CAL_SAMPLES);
    // ceil(2^31 / N): exact quotient for magnitudes below 2^24 and N up to 128
    localparam longint unsigned RecipL =
        ((64'd1 << 31) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [31:0] Recip = 32'(RecipL);

    logic [CW-1:0]      r_cnt;
    logic signed [23:0] r_sum [6];
    logic signed [15:0] r_off [6];
    logic               r_div;
    logic [2:0]         r_ax;

    logic signed [15:0] w_v [6];
    logic               w_acc;
    logic signed [23:0] w_sel;
    logic [23:0]        w_mag;
    logic [55:0]        w_prod;
    logic [23:0]        w_q;
    logic signed [23:0] w_avg;

    always_comb begin
        for (int k = 0; k < 6; k++) w_v[k] = i_data[16*k +: 16];
    end

    assign o_ready = !r_div && (!o_valid || i_ready);
    assign w_acc   = i_valid && o_ready;

    // Truncating average of one axis sum
    assign w_sel  = r_sum[r_ax];
    assign w_mag  = (w_sel < 0) ? 24'(-w_sel) : 24'(w_sel);
    assign w_prod = 56'(w_mag) * 56'(Recip);
    assign w_q    = 24'(w_prod >> 31);
    assign w_avg  = (w_sel < 0) ? -$signed(w_q) : $signed(w_q);

    // Accept, accumulate and latch offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_div   <= 1'b0;
            r_ax    <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_sum[k] <= '0;
                r_off[k] <= '0;
            end
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (w_acc) begin
                o_valid <= 1'b1;
                if (r_cnt < CalN) begin
                    o_work.cal <= 1'b1;
                    for (int k = 0; k < 6; k++) r_sum[k] <= r_sum[k] + 24'(w_v[k]);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == CalN) begin
                        r_div <= 1'b1;
                        r_ax  <= '0;
                    end
                end else begin
                    o_work.cal <= 1'b0;
                end
                o_work.c0 <= w_v[0] - r_off[0];
                o_work.c1 <= w_v[1] - r_off[1];
                o_work.c2 <= w_v[2] - r_off[2];
                o_work.c3 <= w_v[3] - r_off[3];
                o_work.c4 <= w_v[4] - r_off[4];
                o_work.c5 <= w_v[5] - r_off[5];
            end else if (r_div) begin
                r_off[r_ax] <= (r_ax == 3'd2) ? 16'(w_avg - 24'(i_gravity))
                                             : 16'(w_avg);
                if (r_ax == 3'd5) begin
                    r_div <= 1'b0;
                end else begin
                    r_ax <= r_ax + 1'b1;
                end
            end
        end
    end

    // Offsets are set only once the whole sum is known
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div |-> !o_ready)
        else $error("front accepted an item during offset division");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CalN)
        else $error("sample count ran past calibration length");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt < CalN) |-> !r_div)
        else $error("division began before calibration ended");

endmodule
`default_nettype wire

// ===== hdl/imutcf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imutcf_fifo: two-entry queue between front and back end
// Lets either side stall without holding the other.
// ----------------------------------------------------------------------------
module imutcf_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  imutcf_pkg::t_work i_work,
    output logic              o_valid,
    input  wire               i_ready,
    output imutcf_pkg::t_work o_work
);
    imutcf_pkg::t_work r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_wr, w_rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;
    assign o_work  = r_mem[r_rp];

    // Write entry
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_work;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("full queue with unequal pointers");

endmodule
`default_nettype wire

// ===== hdl/imutcf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imutcf_back: angle engine
// Integer square root two bits a cycle, two CORDIC vectorings sharing one
// iteration counter, then gyro step, blend and saturation.
// ----------------------------------------------------------------------------
module imutcf_back #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  imutcf_pkg::t_work   i_work,
    input  wire  [16:0]         i_blend,
    input  wire  [15:0]         i_gain,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [51:0]         o_data
);
    localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

    imutcf_pkg::t_bstate r_st, n_st;
    imutcf_pkg::t_work   r_w;

    // sqrt state: 48-bit radicand, 24-bit root
    logic [47:0] r_n;
    logic [49:0] r_rem;
    logic [23:0] r_root;
    logic [4:0]  r_i;

    // CORDIC state, pitch (p) and roll (r) in parallel
    logic signed [27:0] r_px, r_py, r_rx, r_ry;
    logic signed [31:0] r_pz, r_rz;
    logic               r_pzero, r_rzero;

    logic signed [31:0] r_ang [3];
    logic signed [47:0] r_prod [3];
    logic [1:0]         r_k;

    logic [49:0] w_rem2, w_try;
    logic signed [31:0] w_at;

    assign o_ready = (r_st == imutcf_pkg::S_IDLE);
    assign w_at    = imutcf_pkg::atan_tab(r_i);

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            imutcf_pkg::S_IDLE:  if (i_valid) n_st = i_work.cal ? imutcf_pkg::S_DONE
                                                                 : imutcf_pkg::S_SQRT;
            imutcf_pkg::S_SQRT:  if (r_i == 5'd23) n_st = imutcf_pkg::S_PREP;
            imutcf_pkg::S_PREP:  n_st = imutcf_pkg::S_CORD;
            imutcf_pkg::S_CORD:  if (r_i == LastStep) n_st = imutcf_pkg::S_MUL;
            imutcf_pkg::S_MUL:   n_st = imutcf_pkg::S_BLEND;
            imutcf_pkg::S_BLEND: if (r_k == 2'd2) n_st = imutcf_pkg::S_DONE;
            imutcf_pkg::S_DONE:  if (!o_valid || i_ready) n_st = imutcf_pkg::S_IDLE;
            default:             n_st = imutcf_pkg::S_IDLE;
        endcase
    end

    // Square root trial: two radicand bits per cycle
    assign w_rem2 = {r_rem[47:0], r_n[47:46]};
    assign w_try  = w_rem2 - {24'd0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= imutcf_pkg::S_IDLE;
        else          r_st <= n_st;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        logic signed [31:0] sq1, sq2;
        logic signed [27:0] ya, xa, yb, xb;
        logic signed [34:0] st;
        logic signed [17:0] a;
        logic signed [34:0] bl;
        logic signed [34:0] yw;
        unique case (r_st)
            imutcf_pkg::S_IDLE: begin
                if (i_valid) begin
                    r_w    <= i_work;
                    sq1    = i_work.c1 * i_work.c1;
                    sq2    = i_work.c2 * i_work.c2;
                    r_n    <= {16'(33'(sq1) + 33'(sq2) >> 16) , 32'((33'(sq1) + 33'(sq2)) << 16)};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_i    <= '0;
                end
            end
            imutcf_pkg::S_SQRT: begin
                if (!w_try[49]) begin
                    r_rem  <= w_try;
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[22:0], 1'b0};
                end
                r_n <= {r_n[45:0], 2'b00};
                r_i <= r_i + 1'b1;
            end
            imutcf_pkg::S_PREP: begin
                // pitch: y = -c0*256, x = mag ; roll: y = c1*256, x = c2*256
                ya = -(28'(r_w.c0) <<< 8);
                xa = 28'(r_root);
                yb = 28'(r_w.c1) <<< 8;
                xb = 28'(r_w.c2) <<< 8;
                r_pzero <= (ya == 0) && (xa == 0);
                r_rzero <= (yb == 0) && (xb == 0);
                r_pz <= '0;
                r_rz <= '0;
                if (xa < 0) begin
                    if (ya >= 0) begin r_px <= ya; r_py <= -xa; r_pz <= imutcf_pkg::Deg90; end
                    else begin r_px <= -ya; r_py <= xa; r_pz <= -imutcf_pkg::Deg90; end
                end else begin
                    r_px <= xa; r_py <= ya;
                end
                if (xb < 0) begin
                    if (yb >= 0) begin r_rx <= yb; r_ry <= -xb; r_rz <= imutcf_pkg::Deg90; end
                    else begin r_rx <= -yb; r_ry <= xb; r_rz <= -imutcf_pkg::Deg90; end
                end else begin
                    r_rx <= xb; r_ry <= yb;
                end
                r_i <= '0;
            end
            imutcf_pkg::S_CORD: begin
                if (r_py >= 0) begin
                    r_px <= r_px + (r_py >>> r_i); r_py <= r_py - (r_px >>> r_i);
                    r_pz <= r_pz + w_at;
                end else begin
                    r_px <= r_px - (r_py >>> r_i); r_py <= r_py + (r_px >>> r_i);
                    r_pz <= r_pz - w_at;
                end
                if (r_ry >= 0) begin
                    r_rx <= r_rx + (r_ry >>> r_i); r_ry <= r_ry - (r_rx >>> r_i);
                    r_rz <= r_rz + w_at;
                end else begin
                    r_rx <= r_rx - (r_ry >>> r_i); r_ry <= r_ry + (r_rx >>> r_i);
                    r_rz <= r_rz - w_at;
                end
                r_i <= r_i + 1'b1;
            end
            imutcf_pkg::S_MUL: begin
                // gyro step per axis, one small multiply each
                r_prod[0] <= r_w.c3 * $signed({1'b0, i_gain});
                r_prod[1] <= r_w.c4 * $signed({1'b0, i_gain});
                r_prod[2] <= r_w.c5 * $signed({1'b0, i_gain});
                if (r_pzero) r_pz <= '0;
                if (r_rzero) r_rz <= '0;
                r_k <= '0;
            end
            imutcf_pkg::S_BLEND: begin
                // one axis per cycle
                a  = (i_blend > 17'd65536) ? 18'sd65536 : $signed({1'b0, i_blend});
                st = 35'(r_ang[r_k]) + 35'((r_prod[r_k] + 48'sd128) >>> 8);
                if (r_k == 2'd2) begin
                    yw = st;
                    if (yw >= 35'(imutcf_pkg::Deg180)) yw = yw - 35'(imutcf_pkg::Deg360);
                    else if (yw < -35'(imutcf_pkg::Deg180)) yw = yw + 35'(imutcf_pkg::Deg360);
                    r_ang[2] <= 32'(yw);
                end else begin
                    bl = 35'((a * 53'(st) + (18'sd65536 - a) *
                          53'(r_k == 2'd0 ? r_pz : r_rz) + 53'sd32768) >>> 16);
                    if (bl > 35'(imutcf_pkg::Deg180 - 1)) r_ang[r_k] <= imutcf_pkg::Deg180 - 1;
                    else if (bl < -35'(imutcf_pkg::Deg180)) r_ang[r_k] <= -imutcf_pkg::Deg180;
                    else r_ang[r_k] <= 32'(bl);
                end
                r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_ang[k] <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (r_st == imutcf_pkg::S_DONE && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
                if (r_w.cal) o_data <= {1'b1, 51'd0};
                else o_data <= {1'b0, r_ang[2][24:8], r_ang[1][24:8], r_ang[0][24:8]};
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == imutcf_pkg::S_CORD) |-> (r_i <= LastStep))
        else $error("CORDIC step counter overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == imutcf_pkg::S_BLEND) |-> (r_k <= 2'd2))
        else $error("blend axis counter overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

// ===== hdl/imu_tilt_complementary_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: front register, queue, back end. Calibration samples skip to the
//   back-end output; filtered samples pass 24 square-root steps, the CORDIC
//   loop, gyro multiply and blend; the back end takes one item at a time.
// After the last calibration sample the front end turns six sums into
//   offsets, one per cycle, accepting no item meanwhile.
// Reset (i_rst_n low, synchronous) clears counts, sums, offsets and angles.
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_unit: six-axis pitch/roll/yaw estimator
// Front end calibrates and removes offsets, back end computes the angles.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_unit #(
    parameter int unsigned CAL_SAMPLES  = 100,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z from bit 0 up
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pitch_deg, roll_deg, yaw_deg, calibrating from bit 0 up, zero padded
    output logic [55:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [16:0] i_cfg_data
);
    logic [16:0] r_blend;
    logic [15:0] r_gain;
    logic [14:0] r_grav;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= 17'd64225;
            r_gain  <= 16'd1281;
            r_grav  <= 15'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imutcf_pkg::RegBlend:   r_blend <= i_cfg_data;
                imutcf_pkg::RegGain:    r_gain  <= i_cfg_data[15:0];
                imutcf_pkg::RegGravity: r_grav  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic              w_fv, w_fr, w_qv, w_qr;
    imutcf_pkg::t_work w_fw, w_qw;
    logic [51:0]       w_out;

    imutcf_front #(.CAL_SAMPLES(CAL_SAMPLES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_gravity(r_grav),
        .o_valid(w_fv), .i_ready(w_fr), .o_work(w_fw)
    );

    imutcf_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_work(w_fw),
        .o_valid(w_qv), .i_ready(w_qr), .o_work(w_qw)
    );

    imutcf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_work(w_qw),
        .i_blend(r_blend), .i_gain(r_gain),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_out)
    );

    assign m_axis_tdata = {4'b0000, w_out};

endmodule
`default_nettype wire

// ===== tb/sv/imu_tilt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_checker: angle predictor and result checker of the tilt filter
// Watches the sample, result and configuration ports, keeps its own copy of
// calibration sums, offsets, angles and registers, predicts each result and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module imu_tilt_checker #(
    parameter int unsigned CAL_SAMPLES  = 100,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [95:0] i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [55:0] i_m_tdata,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [16:0] pitch;
        logic [16:0] roll;
        logic [16:0] yaw;
        logic        cal;
    } t_angles;

    localparam longint AtanDeg [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    t_angles     angles_q[$];
    longint      alpha_w;
    longint      step_gain;
    int          grav_cnt;
    int          cal_count;
    int          axis_sum [6];
    int          axis_off [6];
    longint      angle_q16 [3];

    function automatic int wrap16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // CORDIC vectoring, result in Q16.16 degrees
    function automatic longint vec_angle(input longint y, input longint x);
        longint z;
        longint t;
        longint nx;
        longint ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = imutcf_pkg::Deg90;
            end else begin
                x = -y; y = t; z = -imutcf_pkg::Deg90;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + AtanDeg[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - AtanDeg[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint clamp_tilt(input longint v);
        if (v > longint'(imutcf_pkg::Deg180) - 1) return longint'(imutcf_pkg::Deg180) - 1;
        if (v < -longint'(imutcf_pkg::Deg180)) return -longint'(imutcf_pkg::Deg180);
        return v;
    endfunction

    function automatic longint mix(input longint gyro_p, input longint acc_p, input longint a);
        return (a * gyro_p + (65536 - a) * acc_p + 32768) >>> 16;
    endfunction

    // Advance the filter state by one sample and queue the angles it yields
    task automatic predict_sample(input logic [95:0] d);
        int          raw [6];
        int          corr [6];
        longint      a;
        longint      inc [3];
        longint      mag;
        longint      acc_pitch;
        longint      acc_roll;
        longint      yw;
        longint unsigned sq;
        logic signed [15:0] f;
        t_angles     e;
        for (int i = 0; i < 6; i++) begin
            f = d[16*i +: 16];
            raw[i] = int'(f);
        end
        if (cal_count < CAL_SAMPLES) begin
            for (int i = 0; i < 6; i++) axis_sum[i] += raw[i];
            cal_count++;
            if (cal_count >= CAL_SAMPLES) begin
                for (int i = 0; i < 6; i++) begin
                    a = axis_sum[i] / int'(CAL_SAMPLES);
                    if (i == 2) a = a - grav_cnt;
                    axis_off[i] = wrap16(int'(a));
                end
            end
            e = '{pitch: '0, roll: '0, yaw: '0, cal: 1'b1};
        end else begin
            a = (alpha_w > 65536) ? 65536 : alpha_w;
            for (int i = 0; i < 6; i++) corr[i] = wrap16(raw[i] - axis_off[i]);
            for (int i = 0; i < 3; i++) inc[i] = (longint'(corr[3+i]) * step_gain + 128) >>> 8;
            sq = longint'(corr[1]) * corr[1] + longint'(corr[2]) * corr[2];
            mag = longint'(int_sqrt(sq << 16));
            acc_pitch = vec_angle(-longint'(corr[0]) * 256, mag);
            acc_roll  = vec_angle(longint'(corr[1]) * 256, longint'(corr[2]) * 256);
            angle_q16[0] = clamp_tilt(mix(angle_q16[0] + inc[0], acc_pitch, a));
            angle_q16[1] = clamp_tilt(mix(angle_q16[1] + inc[1], acc_roll, a));
            // wrap yaw into one turn around zero
            yw = angle_q16[2] + inc[2];
            if (yw >= longint'(imutcf_pkg::Deg180)) yw = yw - longint'(imutcf_pkg::Deg360);
            else if (yw < -longint'(imutcf_pkg::Deg180)) yw = yw + longint'(imutcf_pkg::Deg360);
            angle_q16[2] = yw;
            e.pitch = 17'(angle_q16[0] >>> 8);
            e.roll  = 17'(angle_q16[1] >>> 8);
            e.yaw   = 17'(angle_q16[2] >>> 8);
            e.cal   = 1'b0;
        end
        angles_q.push_back(e);
    endtask

    // Compare results first, then take new samples and register writes
    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (!i_rst_n) begin
            angles_q.delete();
            alpha_w      = 64225;
            step_gain    = 1281;
            grav_cnt     = 16384;
            cal_count    = 0;
            o_fail_count = 0;
            o_checked    = 0;
            for (int i = 0; i < 6; i++) begin
                axis_sum[i] = 0;
                axis_off[i] = 0;
            end
            for (int i = 0; i < 3; i++) angle_q16[i] = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.pitch = i_m_tdata[16:0];
                got.roll  = i_m_tdata[33:17];
                got.yaw   = i_m_tdata[50:34];
                got.cal   = i_m_tdata[51];
                o_checked++;
                if (angles_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %h", $realtime, i_m_tdata);
                end else begin
                    want = angles_q.pop_front();
                    if (got.pitch != want.pitch || got.roll != want.roll ||
                        got.yaw != want.yaw || got.cal != want.cal ||
                        i_m_tdata[55:52] != 4'd0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch pitch %0d/%0d roll %0d/%0d",
                                      " yaw %0d/%0d cal %0d/%0d"},
                                     $realtime, $signed(want.pitch), $signed(got.pitch),
                                     $signed(want.roll), $signed(got.roll),
                                     $signed(want.yaw), $signed(got.yaw), want.cal, got.cal);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_sample(i_s_tdata);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    imutcf_pkg::RegBlend:   alpha_w   = i_cfg_data;
                    imutcf_pkg::RegGain:    step_gain = i_cfg_data[15:0];
                    imutcf_pkg::RegGravity: grav_cnt  = i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        o_pending = angles_q.size();
    end

endmodule

// ===== tb/sv/tb_imu_tilt_complementary_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_tilt_complementary_filter_unit: stimulus and verdict for the filter
// Calibrates with known offsets, runs directed extremes, then random samples
// over several register settings and idle patterns; a checker predicts.
// ----------------------------------------------------------------------------
module tb_imu_tilt_complementary_filter_unit;

    localparam int CalSamples = 100;
    localparam int Limit      = 600000;
    localparam int Drain      = 250;
    localparam int PerPhase   = 125;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = imutcf_pkg::RegBlend;
    logic [16:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int sent = 0;
    int tx_idle_pct = 10;
    int rx_idle_pct = 81;

    imu_tilt_complementary_filter_unit #(.CAL_SAMPLES(CalSamples)) uut (.*);

    imu_tilt_checker #(.CAL_SAMPLES(CalSamples)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > Limit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [95:0] pack6(input int ax, input int ay, input int az,
                                          input int gx, input int gy, input int gz);
        return {16'(gz), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic logic [95:0] rand_sample();
        int f [6];
        int span;
        if ($urandom_range(3) == 0) return {$urandom, $urandom, $urandom};
        span = $urandom_range(1) ? 300 : 32767;
        for (int k = 0; k < 3; k++) f[k] = int'($urandom_range(40000)) - 20000;
        for (int k = 3; k < 6; k++) f[k] = int'($urandom_range(2 * span)) - span;
        return pack6(f[0], f[1], f[2], f[3], f[4], f[5]);
    endfunction

    // Offer one item, with a random gap before it
    task automatic push(input logic [95:0] d);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (sent == 400) begin
            tx_idle_pct = 81; rx_idle_pct = 10;
        end else if (sent == 800) begin
            tx_idle_pct = 0; rx_idle_pct = 0;
        end
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Drain) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 17'(val);
        @(posedge i_clk);
    endtask

    initial begin
        int grav;
        int nz;
        int n [6];
        int blends [8];
        int gains [8];
        blends = '{64225, 0, 65536, 131071, 0, 32768, 64225, 0};
        gains  = '{1281, 0, 65535, 65535, 0, 1281, 20000, 0};
        blends[4] = $urandom_range(65536);
        blends[7] = $urandom_range(131071);
        gains[4]  = $urandom_range(65535);
        gains[7]  = $urandom_range(65535);
        case ($urandom_range(3))
            0: grav = 0;
            1: grav = 32767;
            2: grav = 16384;
            default: grav = $urandom_range(32767);
        endcase

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gravity first, so that calibration leaves zero offsets
        cfg_write(imutcf_pkg::RegGravity, grav);
        cfg_write(imutcf_pkg::RegBlend, 64225);
        cfg_write(imutcf_pkg::RegGain, 1281);
        cfg_write(2'd3, 17'h1ffff);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        // Calibrate with samples in canceling pairs around (0, 0, grav)
        for (int p = 0; p < CalSamples / 2; p++) begin
            for (int k = 0; k < 6; k++)
                n[k] = (p % 10 == 0) ? 32767 : int'($urandom_range(2000));
            nz = (n[2] > 32767 - grav) ? 32767 - grav : n[2];
            push(pack6(n[0], n[1], grav + nz, n[3], n[4], n[5]));
            push(pack6(-n[0], -n[1], grav - nz, -n[3], -n[4], -n[5]));
        end

        // Directed: zero vector, quadrant turns, field extremes
        push(pack6(0, 0, 0, 0, 0, 0));
        push(pack6(32767, 0, 0, 0, 0, 0));
        push(pack6(-32768, 0, 0, 0, 0, 0));
        push(pack6(0, 32767, -32768, 0, 0, 0));
        push(pack6(0, -32768, -32768, 0, 0, 0));
        push(pack6(0, 0, 32767, 0, 0, 0));
        push(pack6(-32768, -32768, -32768, -32768, -32768, -32768));
        push(pack6(32767, 32767, 32767, 32767, 32767, 32767));
        push(pack6(0, 0, 16384, 32767, -32768, 0));
        push(pack6(0, 0, 16384, 0, 0, -32768));
        for (int k = 0; k < 8; k++) push(pack6(0, 0, 16384, 32767, -32768, 32767));

        // Late gravity write must not matter
        settle();
        cfg_write(imutcf_pkg::RegGravity, $urandom_range(32767));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        // Random samples across register settings
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            cfg_write(imutcf_pkg::RegBlend, blends[ph]);
            cfg_write(imutcf_pkg::RegGain, gains[ph]);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            for (int k = 0; k < PerPhase; k++) begin
                if (ph == 3 && k == 60) settle();
                push(rand_sample());
            end
        end

        settle();
        $display("Sent %0d samples (calibration, directed, 8 register settings);", sent);
        $display("checked %0d results under three idle patterns.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/imutcf_pkg.sv
hdl/imutcf_front.sv
hdl/imutcf_fifo.sv
hdl/imutcf_back.sv
hdl/imu_tilt_complementary_filter_unit.sv
tb/sv/imu_tilt_checker.sv
tb/sv/tb_imu_tilt_complementary_filter_unit.sv
